// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the RTL folder.
// No dependencies; the clock is clk and the reset rst_n in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/sha_pkg.sv
// Shared types, constants and functions of the SHA-256 block hash.
// No dependencies; used by the schedule, core and top-level modules.
package sha_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Control word from the sequencer to the datapath modules
  typedef struct packed {
    logic       load;  // shift a message word into the schedule
    logic       init;  // load the initial hash value into a..h
    logic       rnd;   // run one compression round
    logic [5:0] t;     // round index
  } sha_ctl_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t small_s0(word_t v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ (v >> 3);
  endfunction

  function automatic word_t small_s1(word_t v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ (v >> 10);
  endfunction

  function automatic word_t big_s0(word_t v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic word_t big_s1(word_t v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

endpackage

// File: hw/rtl/sha_ifs.sv
// Valid/ready channel interfaces of the SHA-256 block hash.
// Depends on sha_pkg for the word type.
interface sha_in_if;
  logic                valid;
  logic                ready;
  sha_pkg::word_t      message_word;

  modport source (output valid, output message_word, input ready);
  modport sink   (input valid, input message_word, output ready);
endinterface

interface sha_out_if;
  logic                valid;
  logic                ready;
  sha_pkg::word_t      digest_word;
  logic                digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

// File: hw/rtl/sha_sched.sv
// Message schedule: a sixteen-word shift line that expands W[16..63].
// Depends on sha_pkg for the control struct and the sigma functions.
module sha_sched (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  input  sha_pkg::word_t    in_word,
  output sha_pkg::word_t    w
);

  sha_pkg::word_t win_r [16];
  sha_pkg::word_t new_w;
  sha_pkg::word_t shift_in;

  // Expand the next schedule word from the window taps
  assign new_w = sha_pkg::small_s1(win_r[14]) + win_r[9]
               + sha_pkg::small_s0(win_r[1]) + win_r[0];

  assign shift_in = ctl.load ? in_word : new_w;
  assign w        = win_r[0];

  // Advance the window on every loaded word and every round
  always_ff @(posedge clk) begin
    if (ctl.load || ctl.rnd) begin
      for (int j = 0; j < 15; j++) begin
        win_r[j] <= win_r[j+1];
      end
      win_r[15] <= shift_in;
    end
  end

endmodule

// File: hw/rtl/sha_core.sv
// Compression round unit: working variables a..h and the shared round logic.
// Depends on sha_pkg for constants, the control struct and the sigma functions.
module sha_core (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  input  sha_pkg::word_t    w,
  input  logic [2:0]        dig_idx,
  output sha_pkg::word_t    dig_word
);

  sha_pkg::word_t v_r [8];
  sha_pkg::word_t t1;
  sha_pkg::word_t t2;
  sha_pkg::word_t ch;
  sha_pkg::word_t maj;

  // Round function on the current working variables
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + sha_pkg::big_s1(v_r[4]) + ch + sha_pkg::K[ctl.t] + w;
  assign t2  = sha_pkg::big_s0(v_r[0]) + maj;

  // Digest word: initial value plus final working variable
  assign dig_word = sha_pkg::IV[dig_idx] + v_r[dig_idx];

  // Load the initial value, or rotate a..h through one round
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int j = 0; j < 8; j++) begin
        v_r[j] <= sha_pkg::IV[j];
      end
    end else if (ctl.rnd) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

// File: hw/rtl/sha256_block_hash.sv
// SHA-256 single-block hash, top level with the round sequencer.
// Input channel in_ch: one 32-bit big-endian message word per handshake,
// sixteen words make one already-padded 512-bit block. Each block is hashed
// from the standard initial value; blocks are not chained.
// Result channel out_ch: eight digest words H0..H7, digest_last set on H7.
// Timing: words are taken one per cycle while loading. After the sixteenth
// word in_ch.ready drops and the shared round unit runs 64 rounds; then the
// digest words leave through an output register, one per cycle when the
// receiver is ready. The single round unit bounds the block rate, and no
// word of the next block is taken before H7 is loaded.
// When the receiver stalls, the current digest word holds and the sequencer
// waits; once H7 sits in the output register the next block may load.
// Reset (rst_n low, synchronous) drops all valids and restarts at word 0.
// Depends on sha_pkg, sha_ifs, sha_sched and sha_core.
module sha256_block_hash (
  input  logic             clk,
  input  logic             rst_n,
  sha_in_if.sink           in_ch,
  sha_out_if.source        out_ch
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [3:0]        wcnt_r, wcnt_nxt;
  logic [5:0]        rnd_r, rnd_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              out_valid_r;
  sha_pkg::word_t    out_word_r;
  logic              out_last_r;
  logic              in_acc;
  logic              out_load;
  sha_pkg::sha_ctl_t ctl;
  sha_pkg::word_t    w;
  sha_pkg::word_t    dig_word;

  assign in_ch.ready        = (state_r == ST_LOAD);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_load           = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.digest_last = out_last_r;

  // Drive the datapath control word
  assign ctl.load = in_acc;
  assign ctl.init = in_acc && (wcnt_r == 4'd15);
  assign ctl.rnd  = (state_r == ST_ROUND);
  assign ctl.t    = rnd_r;

  // Sequencer: load sixteen words, run 64 rounds, emit eight digest words
  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          wcnt_nxt = wcnt_r + 4'd1;
          if (wcnt_r == 4'd15) begin
            state_nxt = ST_ROUND;
            rnd_nxt   = '0;
          end
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      wcnt_r  <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Output register: hold a stalled word, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= dig_word;
      out_last_r <= (idx_r == 3'd7);
    end
  end

  sha_sched u_sched (
    .clk     (clk),
    .ctl     (ctl),
    .in_word (in_ch.message_word),
    .w       (w)
  );

  sha_core u_core (
    .clk      (clk),
    .ctl      (ctl),
    .w        (w),
    .dig_idx  (idx_r),
    .dig_word (dig_word)
  );

endmodule

// File: hw/rtl/sha_chk.sv
// Port-level checker for the SHA-256 block hash, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module sha_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic        out_digest_last
);

  // A stalled digest word holds
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_digest_word) && $stable(out_digest_last), "digest word changed while stalled")

  // No message word is taken while a digest other than H7 waits
  `ASSERT_CLK(a_no_load_mid_digest, out_valid && !out_digest_last |-> !in_ready, "input ready in the middle of a digest")

  // After H7 is taken, the output valid must drop
  `ASSERT_CLK(a_gap_after_last, out_valid && out_ready && out_digest_last |=> !out_valid, "output right after the last digest word")

  // Reset clears the output valid
  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind sha256_block_hash sha_chk u_sha_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_digest_last (out_ch.digest_last)
);
